### hdl/checksummed_frame_field_parser_macros.svh
// assertion helpers used by the top parser file
`ifndef CHECKSUMMED_FRAME_FIELD_PARSER_MACROS_SVH
`define CHECKSUMMED_FRAME_FIELD_PARSER_MACROS_SVH

// same-cycle implication
`define CFFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cffp_pkg.sv
package cffp_pkg;

  localparam int MAX_FIELDS_DEF    = 8;
  localparam int PAYLOAD_BYTES_DEF = 64;

  localparam int BYTE_W     = 8;
  localparam int CODES_W    = 16;
  localparam int COUNT_W    = 4;
  localparam int VALUE_W    = 64;
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 3;
  localparam int TOTAL_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int CMD_DEPTH  = 2;

  localparam logic [CODES_W-1:0] FORMAT_RESET = 16'd3;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 4'd1;

  localparam logic [BYTE_W-1:0] START_MARK = 8'h53;
  localparam logic [23:0]       END_MARK   = 24'h454E44;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOUBLE = 2'd0,
    KIND_FLOAT  = 2'd1,
    KIND_WORD   = 2'd2,
    KIND_BYTE   = 2'd3
  } cffp_kind_t;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_COUNT  = 1'b1
  } cffp_reg_t;

  // frame verdict handed from the front to the back
  typedef struct packed {
    logic               ok;
    logic               bank;
    logic [TOTAL_W-1:0] total;
  } cffp_cmd_t;

  // back tells the front that a payload bank may be refilled
  typedef struct packed {
    logic free;
    logic bank;
  } cffp_rel_t;

  function automatic logic [3:0] field_size(logic [KIND_W-1:0] code);
    logic [3:0] sz;
    unique case (cffp_kind_t'(code))
      KIND_DOUBLE: sz = 4'd8;
      KIND_FLOAT:  sz = 4'd4;
      KIND_WORD:   sz = 4'd4;
      KIND_BYTE:   sz = 4'd1;
    endcase
    return sz;
  endfunction

endpackage

### hdl/cffp_if.sv
interface cffp_in_if import cffp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface cffp_out_if import cffp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] field_value;
  logic [KIND_W-1:0]  field_kind;
  logic [INDEX_W-1:0] field_index;
  logic               frame_error;
  logic [TOTAL_W-1:0] error_total;
  logic               last_of_frame;

  modport source(output valid, output field_value, output field_kind, output field_index,
                 output frame_error, output error_total, output last_of_frame,
                 input ready);
  modport sink(input valid, input field_value, input field_kind, input field_index,
               input frame_error, input error_total, input last_of_frame,
               output ready);
endinterface

### hdl/cffp_ram.sv
module cffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cffp_fifo.sv
module cffp_fifo import cffp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cffp_cmd_t din,
  output logic      full,
  input  logic      pop,
  output cffp_cmd_t dout,
  output logic      empty
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cffp_cmd_t          entries [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(CMD_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/cffp_front.sv
module cffp_front import cffp_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int LEN_W         = 7,
  parameter int AW            = 7
) (
  input  logic           clk,
  input  logic           rst,
  cffp_in_if.sink        byte_ch,
  input  logic [LEN_W-1:0] len,
  input  logic           q_full,
  output logic           push,
  output cffp_cmd_t      cmd,
  input  cffp_rel_t      rel,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata
);

  localparam int IDX_W = AW - 1;

  logic               in_frame;
  logic [15:0]        byte_count;
  logic [BYTE_W-1:0]  payload_sum;
  logic [BYTE_W-1:0]  check_byte;
  logic [23:0]        tail_bytes;
  logic [TOTAL_W-1:0] reject_count;
  logic               wbank;
  logic [1:0]         bank_busy;
  logic [1:0]         bank_busy_next;

  logic               accept;
  logic [BYTE_W-1:0]  b;
  logic [15:0]        len16;
  logic [15:0]        off;
  logic               is_payload;
  logic               is_check;
  logic [BYTE_W-1:0]  sum_next;
  logic [BYTE_W-1:0]  check_next;
  logic [15:0]        count_next;
  logic [23:0]        tail_next;
  logic               closing;
  logic               good;
  logic [TOTAL_W-1:0] total_inc;

  // a new byte waits while the write bank is still being read out or the queue is full
  assign byte_ch.ready = !q_full && !bank_busy[wbank];
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign b             = byte_ch.in_byte;

  always_comb begin
    len16      = 16'(len);
    off        = byte_count - 16'd3;
    is_payload = (byte_count >= 16'd3) && (off < len16);
    is_check   = !is_payload && (byte_count == len16 + 16'd3);
    sum_next   = is_payload ? payload_sum + b : payload_sum;
    check_next = is_check ? b : check_byte;
    count_next = (byte_count < 16'hFFFF) ? byte_count + 16'd1 : byte_count;
    tail_next  = {tail_bytes[15:0], b};
    closing    = in_frame && (count_next >= len16 + 16'd7) && (tail_next == END_MARK);
    good       = (count_next == len16 + 16'd7) && (sum_next == check_next);
    total_inc  = (reject_count != '1) ? reject_count + TOTAL_W'(1) : reject_count;
  end

  // a bank is released by the back end and claimed by an accepted frame
  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.free) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (accept && closing && good) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  assign ram_we    = accept && in_frame && is_payload && (off < PAYLOAD_BYTES);
  assign ram_waddr = {wbank, off[IDX_W-1:0]};
  assign ram_wdata = b;

  assign push      = accept && closing;
  assign cmd.ok    = good;
  assign cmd.bank  = wbank;
  assign cmd.total = good ? reject_count : total_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= '0;
      payload_sum  <= '0;
      check_byte   <= '0;
      tail_bytes   <= '0;
      reject_count <= '0;
      wbank        <= 1'b0;
      bank_busy    <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (!in_frame) begin
          if (b == START_MARK) begin
            in_frame    <= 1'b1;
            byte_count  <= 16'd1;
            payload_sum <= '0;
            check_byte  <= '0;
            tail_bytes  <= {16'd0, b};
          end
        end else if (closing) begin
          in_frame    <= 1'b0;
          byte_count  <= '0;
          tail_bytes  <= '0;
          payload_sum <= '0;
          check_byte  <= '0;
          if (good) begin
            wbank <= ~wbank;
          end else begin
            reject_count <= total_inc;
          end
        end else begin
          byte_count  <= count_next;
          payload_sum <= sum_next;
          check_byte  <= check_next;
          tail_bytes  <= tail_next;
        end
      end
    end
  end

endmodule

### hdl/cffp_back.sv
module cffp_back import cffp_pkg::*; #(
  parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int NF_W          = 4,
  parameter int AW            = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cffp_cmd_t          cmd,
  output logic               pop,
  input  logic [CODES_W-1:0] format_codes,
  input  logic [NF_W-1:0]    nf,
  output logic [AW-1:0]      ram_raddr,
  input  logic [BYTE_W-1:0]  ram_rdata,
  output cffp_rel_t          rel,
  cffp_out_if.source         result_ch
);

  localparam int IDX_W = AW - 1;
  localparam int POS_W = $clog2(8 * MAX_FIELDS + 1);
  localparam int SUM_W = (POS_W + 1 > IDX_W) ? POS_W + 1 : IDX_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } state_t;

  state_t             state;
  cffp_cmd_t          cmd_q;
  logic [INDEX_W-1:0] fidx;
  logic [POS_W-1:0]   pos;
  logic [3:0]         kb;
  logic               pend;
  logic [2:0]         pend_k;
  logic               pend_zero;
  logic [VALUE_W-1:0] acc;
  cffp_rel_t          rel_q;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [KIND_W-1:0]  out_kind;
  logic [INDEX_W-1:0] out_index;
  logic               out_err;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;

  logic [KIND_W-1:0]  code;
  logic [3:0]         sz;
  logic [SUM_W-1:0]   rd_sum;
  logic               issue;
  logic               in_range;
  logic               last_field;
  logic               out_free;

  always_comb begin
    code       = format_codes[{fidx, 1'b0} +: KIND_W];
    sz         = field_size(code);
    rd_sum     = SUM_W'(pos) + SUM_W'(kb);
    issue      = kb < sz;
    in_range   = rd_sum < PAYLOAD_BYTES;
    last_field = (int'(fidx) + 1 == int'(nf));
    out_free   = !out_valid || result_ch.ready;
  end

  assign ram_raddr = {cmd_q.bank, rd_sum[IDX_W-1:0]};
  assign pop       = (state == B_IDLE) && cmd_valid;
  assign rel       = rel_q;

  assign result_ch.valid         = out_valid;
  assign result_ch.field_value   = out_value;
  assign result_ch.field_kind    = out_kind;
  assign result_ch.field_index   = out_index;
  assign result_ch.frame_error   = out_err;
  assign result_ch.error_total   = out_total;
  assign result_ch.last_of_frame = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      rel_q     <= '0;
    end else begin
      // the bank is handed back once the last field of a good frame goes out
      rel_q <= '{free: (state == B_EMIT) && out_free && cmd_q.ok && last_field,
                 bank: cmd_q.bank};
      if (out_valid && result_ch.ready && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            fidx  <= '0;
            pos   <= '0;
            kb    <= '0;
            pend  <= 1'b0;
            acc   <= '0;
            state <= cmd.ok ? B_READ : B_EMIT;
          end
        end
        B_READ: begin
          // one store read per cycle, the data lands in the next cycle
          if (issue) begin
            kb        <= kb + 4'd1;
            pend_k    <= kb[2:0];
            pend_zero <= !in_range;
          end
          pend <= issue;
          if (pend) begin
            acc[{pend_k, 3'b000} +: BYTE_W] <= pend_zero ? '0 : ram_rdata;
          end
          if (!issue && !pend) begin
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_total <= cmd_q.total;
            if (cmd_q.ok) begin
              out_value <= acc;
              out_kind  <= code;
              out_index <= fidx;
              out_err   <= 1'b0;
              out_last  <= last_field;
            end else begin
              out_value <= '0;
              out_kind  <= KIND_DOUBLE;
              out_index <= '0;
              out_err   <= 1'b1;
              out_last  <= 1'b1;
            end
            if (!cmd_q.ok || last_field) begin
              state <= B_IDLE;
            end else begin
              fidx  <= fidx + INDEX_W'(1);
              pos   <= pos + POS_W'(sz);
              kb    <= '0;
              acc   <= '0;
              state <= B_READ;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### hdl/checksummed_frame_field_parser.sv
// frame parser for a byte stream: 'S', two free bytes, payload, check byte, "END"
// byte_ch carries one byte per transaction; result_ch carries one field per
// transaction (value, kind, index) or one error result for a rejected frame.
// the payload layout is set over APB: format_codes (addr 0) and field_count (addr 4).
// bytes are taken at up to one per cycle. when the closing 'D' is taken the
// verdict moves through a two-entry queue to the back end, which reads the
// payload store one byte per cycle while it reads a field, then loads that
// field into the result register and goes on to the next field.
// payload bytes go to one of two store banks, so a frame can arrive while the
// previous one is read out; byte_ch.ready drops only when both banks wait
// for readout or the queue is full.
// a stalled result_ch holds the result register; the back end waits on it and the
// front keeps taking bytes until the queue or the banks run out.
// reset clears the frame state, the error count and the queue, and sets
// format_codes to 3 and field_count to 1; the store needs no clearing.
`include "checksummed_frame_field_parser_macros.svh"

module checksummed_frame_field_parser import cffp_pkg::*; #(
  parameter int MAX_FIELDS    = MAX_FIELDS_DEF,
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  cffp_in_if.sink               byte_ch,
  cffp_out_if.source            result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NF_W  = $clog2(MAX_FIELDS + 1);
  localparam int LEN_W = $clog2(8 * MAX_FIELDS + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int AW    = IDX_W + 1;

  logic [CODES_W-1:0] format_codes;
  logic [COUNT_W-1:0] field_count;
  logic [NF_W-1:0]    nf;
  logic [LEN_W-1:0]   len;

  logic               push;
  cffp_cmd_t          cmd;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  cffp_cmd_t          q_head;
  cffp_rel_t          rel;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_codes <= FORMAT_RESET;
      field_count  <= COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cffp_reg_t'(paddr[2]))
        REG_FORMAT: format_codes <= pwdata[CODES_W-1:0];
        REG_COUNT:  field_count  <= pwdata[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cffp_reg_t'(paddr[2]))
      REG_FORMAT: prdata = APB_DATA_W'(format_codes);
      REG_COUNT:  prdata = APB_DATA_W'(field_count);
    endcase
  end

  // fields in use, clamped to 1..MAX_FIELDS, and the payload length they give
  always_comb begin
    if (field_count == '0) begin
      nf = NF_W'(1);
    end else if (field_count > COUNT_W'(MAX_FIELDS)) begin
      nf = NF_W'(MAX_FIELDS);
    end else begin
      nf = NF_W'(field_count);
    end
    len = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      if (i < int'(nf)) begin
        len = len + LEN_W'(field_size(format_codes[2*i +: KIND_W]));
      end
    end
  end

  cffp_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .LEN_W        (LEN_W),
    .AW           (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .len      (len),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd),
    .rel      (rel),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  cffp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cffp_fifo u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd),
    .full (q_full),
    .pop  (pop),
    .dout (q_head),
    .empty(q_empty)
  );

  cffp_back #(
    .MAX_FIELDS   (MAX_FIELDS),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .NF_W         (NF_W),
    .AW           (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!q_empty),
    .cmd         (q_head),
    .pop         (pop),
    .format_codes(format_codes),
    .nf          (nf),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .rel         (rel),
    .result_ch   (result_ch)
  );

  `CFFP_ASSERT_SAME(a_no_push_full, clk, rst, push, !q_full, "verdict pushed into full queue")
  `CFFP_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !q_empty, "verdict popped from empty queue")
  `CFFP_ASSERT_NEXT(a_push_lands, clk, rst, push, !q_empty, "pushed verdict missing from queue")
  `CFFP_ASSERT_SAME(a_error_shape, clk, rst, result_ch.valid && result_ch.frame_error,
    result_ch.last_of_frame && result_ch.error_total != '0 && result_ch.field_value == '0,
    "malformed error result")

endmodule

### tb/sv/cffp_frame_checker.sv
`timescale 1ns / 1ps

module cffp_frame_checker import cffp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cffp_in_if                    byte_ch,
  cffp_out_if                   result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output logic                  frame_open,
  output int                    frame_len
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    cffp_kind_t         kind;
    logic [INDEX_W-1:0] index;
    logic               error;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } field_result_t;

  field_result_t expected_fields[$];

  logic [CODES_W-1:0] fmt_codes;
  logic [COUNT_W-1:0] fld_count;
  int                 byte_cnt;
  logic [BYTE_W-1:0]  run_sum;
  logic [BYTE_W-1:0]  check_val;
  logic [23:0]        tail;
  logic [BYTE_W-1:0]  store [PAYLOAD_BYTES_DEF];
  logic [TOTAL_W-1:0] rejects;

  function automatic int fields_in_use(logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_FIELDS_DEF) return MAX_FIELDS_DEF;
    return int'(c);
  endfunction

  function automatic int kind_bytes(cffp_kind_t k);
    case (k)
      KIND_DOUBLE: return 8;
      KIND_BYTE:   return 1;
      default:     return 4;
    endcase
  endfunction

  function automatic cffp_kind_t kind_of(int i);
    return cffp_kind_t'(fmt_codes[2*i +: 2]);
  endfunction

  function automatic int layout_len();
    int len;
    len = 0;
    for (int i = 0; i < fields_in_use(fld_count); i++) len += kind_bytes(kind_of(i));
    return len;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic take_byte(input logic [BYTE_W-1:0] b);
    int            len;
    int            p;
    int            nf;
    int            pos;
    int            i;
    int            k;
    field_result_t r;
    len = layout_len();
    if (!frame_open) begin
      if (b == START_MARK) begin
        frame_open = 1'b1;
        byte_cnt   = 1;
        run_sum    = '0;
        check_val  = '0;
        tail       = {16'd0, b};
      end
      return;
    end
    p = byte_cnt;
    if (p >= 3 && p - 3 < len) begin
      if (p - 3 < PAYLOAD_BYTES_DEF) store[p-3] = b;
      run_sum += b;
    end else if (p == len + 3) begin
      check_val = b;
    end
    if (p < 16'hFFFF) byte_cnt = p + 1;
    tail = {tail[15:0], b};
    if (byte_cnt < len + 7 || tail != END_MARK) return;
    frame_open = 1'b0;
    if (byte_cnt == len + 7 && run_sum == check_val) begin
      nf  = fields_in_use(fld_count);
      pos = 0;
      for (i = 0; i < nf; i++) begin
        r.kind  = kind_of(i);
        r.value = '0;
        for (k = 0; k < kind_bytes(r.kind); k++) r.value[8*k +: 8] = store[pos + k];
        pos += kind_bytes(r.kind);
        r.index = INDEX_W'(i);
        r.error = 1'b0;
        r.total = rejects;
        r.last  = (i + 1 == nf);
        expected_fields = {expected_fields, r};
      end
    end else begin
      if (rejects != '1) rejects++;
      r.value = '0;
      r.kind  = KIND_DOUBLE;
      r.index = '0;
      r.error = 1'b1;
      r.total = rejects;
      r.last  = 1'b1;
      expected_fields = {expected_fields, r};
    end
    byte_cnt = 0;
    tail     = '0;
  endtask

  task automatic check_result();
    field_result_t want;
    if (expected_fields.size() == 0) begin
      flag_mismatch("result with nothing expected", result_ch.field_value, '0);
      return;
    end
    want = expected_fields.pop_front();
    if (result_ch.field_value !== want.value)
      flag_mismatch("field_value", result_ch.field_value, want.value);
    if (result_ch.field_kind !== want.kind)
      flag_mismatch("field_kind", 64'(result_ch.field_kind), 64'(want.kind));
    if (result_ch.field_index !== want.index)
      flag_mismatch("field_index", 64'(result_ch.field_index), 64'(want.index));
    if (result_ch.frame_error !== want.error)
      flag_mismatch("frame_error", 64'(result_ch.frame_error), 64'(want.error));
    if (result_ch.error_total !== want.total)
      flag_mismatch("error_total", 64'(result_ch.error_total), 64'(want.total));
    if (result_ch.last_of_frame !== want.last)
      flag_mismatch("last_of_frame", 64'(result_ch.last_of_frame), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt_codes  = FORMAT_RESET;
      fld_count  = COUNT_RESET;
      frame_open = 1'b0;
      byte_cnt   = 0;
      run_sum    = '0;
      check_val  = '0;
      tail       = '0;
      rejects    = '0;
      expected_fields.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) check_result();
      if (psel && penable && pwrite && pready) begin
        if (cffp_reg_t'(paddr[2]) == REG_FORMAT) fmt_codes = pwdata[CODES_W-1:0];
        else fld_count = pwdata[COUNT_W-1:0];
      end
      if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.in_byte);
    end
    pending   = expected_fields.size();
    frame_len = layout_len();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cffp_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int LONG_BYTES   = 24;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_EXTRA,
    FRAME_EARLY_END,
    FRAME_BROKEN
  } frame_shape_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;

  cffp_in_if  byte_ch();
  cffp_out_if result_ch();

  int   fail_count;
  int   pending;
  int   frame_len;
  logic frame_open;
  logic byte_taken;
  logic apb_done;
  bit   quiet;
  int   hold_reqs;
  int   holds_done;
  int   cycles;

  checksummed_frame_field_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  cffp_frame_checker field_check (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .result_ch  (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .frame_open (frame_open),
    .frame_len  (frame_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    byte_taken <= byte_ch.valid && byte_ch.ready;
    apb_done   <= psel && penable && pwrite && pready;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold when asked
  initial begin
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      if (stall == 0 && !quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 15);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(negedge clk); while (!byte_taken);
  endtask

  task automatic send_end();
    send_byte(END_MARK[23:16]);
    send_byte(END_MARK[15:8]);
    send_byte(END_MARK[7:0]);
  endtask

  // keep appending the end marker until the frame in progress closes
  task automatic close_frame();
    while (frame_open) send_end();
  endtask

  task automatic send_noise(input int count);
    logic [BYTE_W-1:0] b;
    repeat (count) begin
      b = BYTE_W'($urandom);
      if (b == START_MARK) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input frame_shape_t shape, input int fill);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int                len;
    int                i;
    len = frame_len;
    sum = '0;
    send_byte(START_MARK);
    if (shape == FRAME_BROKEN) begin
      repeat ($urandom_range(0, 20)) send_byte(BYTE_W'($urandom));
    end else begin
      send_byte(BYTE_W'($urandom));
      send_byte(BYTE_W'($urandom));
      if (shape == FRAME_EARLY_END) send_end();
      for (i = 0; i < len; i++) begin
        b = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
        sum += b;
        send_byte(b);
      end
      if (shape == FRAME_BAD_SUM) sum += BYTE_W'($urandom_range(1, 255));
      send_byte(sum);
      // stray bytes below 'D' never form the end marker
      if (shape == FRAME_EXTRA)
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 8'h43)));
      send_end();
    end
    close_frame();
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input cffp_reg_t r, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CODES_W-1:0] fmt, input logic [COUNT_W-1:0] cnt);
    wait_idle();
    apb_write(REG_FORMAT, APB_DATA_W'(fmt));
    apb_write(REG_COUNT, APB_DATA_W'(cnt));
  endtask

  initial begin
    int                 phase;
    int                 pick;
    logic [COUNT_W-1:0] cnt;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    quiet     = 1'b0;
    hold_reqs = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle bytes, then the reset layout of one byte field
    send_byte('0);
    send_byte('1);
    send_byte(END_MARK[23:16]);
    send_frame(FRAME_GOOD, 8'hFF);

    configure(CODES_W'({KIND_BYTE, KIND_WORD, KIND_FLOAT, KIND_DOUBLE}), 4'd4);
    send_frame(FRAME_GOOD, 8'hFF);
    send_frame(FRAME_BAD_SUM, -1);
    send_frame(FRAME_EXTRA, -1);
    send_frame(FRAME_EARLY_END, -1);
    send_frame(FRAME_BROKEN, -1);

    configure('0, 4'd8);
    send_frame(FRAME_GOOD, -1);

    // zero field count acts as one field
    configure('1, '0);
    send_frame(FRAME_GOOD, -1);

    // count above the maximum acts as the maximum
    configure('1, '1);
    send_frame(FRAME_GOOD, 0);

    // overlong frame without the end marker, rejected once it closes
    quiet = 1'b1;
    send_byte(START_MARK);
    repeat (LONG_BYTES) send_byte(BYTE_W'($urandom_range(0, 8'h43)));
    close_frame();
    quiet = 1'b0;

    configure({CODES_W/2{KIND_FLOAT}}, 4'd2);
    send_frame(FRAME_GOOD, -1);

    phase = 0;
    while (phase < 2) begin
      quiet = (phase == 1);
      if (phase == 1) begin
        // short frames against a held result side fill the block up
        configure('1, 4'd2);
        hold_reqs++;
        repeat (6) send_frame(FRAME_GOOD, -1);
      end else begin
        cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 15))
                                          : COUNT_W'($urandom_range(1, 4));
        configure(CODES_W'($urandom), cnt);
        repeat ($urandom_range(2, 4)) begin
          pick = $urandom_range(0, 19);
          if (pick < 13) send_frame(FRAME_GOOD, -1);
          else if (pick < 15) send_frame(FRAME_BAD_SUM, -1);
          else if (pick < 17) send_frame(FRAME_EXTRA, -1);
          else if (pick < 18) send_frame(FRAME_EARLY_END, -1);
          else send_frame(FRAME_BROKEN, -1);
          if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 5));
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/cffp_pkg.sv
hdl/cffp_if.sv
hdl/cffp_ram.sv
hdl/cffp_fifo.sv
hdl/cffp_front.sv
hdl/cffp_back.sv
hdl/checksummed_frame_field_parser.sv
tb/sv/cffp_frame_checker.sv
tb/sv/tb_top.sv
